// ===== src/rebq_pkg.sv =====
`default_nettype none
package rebq_pkg;

   // Input transaction kinds; code 3 is unused and changes nothing
   typedef enum logic [1:0] {
      OP_ENCODER = 2'd0,
      OP_POLL    = 2'd1,
      OP_RAW     = 2'd2
   } op_type;

   // Reported events
   typedef enum logic [2:0] {
      EVT_NONE  = 3'd0,
      EVT_SHORT = 3'd1,
      EVT_LONG  = 3'd2,
      EVT_CCW   = 3'd3,
      EVT_CW    = 3'd4
   } key_event_type;

   // Push button qualifier phases
   typedef enum logic [1:0] {
      PHASE_RELEASED = 2'd0,
      PHASE_VALID    = 2'd1,
      PHASE_LONG     = 2'd2
   } phase_type;

   // Register indexes on the configuration port
   localparam logic [1:0] CSR_STEP_THRESHOLD = 2'd0;
   localparam logic [1:0] CSR_COOLDOWN_POLLS = 2'd1;
   localparam logic [1:0] CSR_DEBOUNCE_POLLS = 2'd2;
   localparam logic [1:0] CSR_LONG_PRESS     = 2'd3;

   localparam logic [6:0]  STEP_THRESHOLD_RST = 7'd4;
   localparam logic [3:0]  COOLDOWN_POLLS_RST = 4'd2;
   localparam logic [7:0]  DEBOUNCE_POLLS_RST = 8'd2;
   localparam logic [15:0] LONG_PRESS_RST     = 16'd50;

   typedef struct packed {
      logic [1:0] operation;
      logic       pin_a;
      logic       pin_b;
      logic       switch_level;
   } req_payload_type;

   typedef struct packed {
      logic [2:0]        key_event;
      logic signed [7:0] raw_steps;
   } rsp_payload_type;

   // Command handed from the input register to the state units
   typedef struct packed {
      logic       fire;
      logic [1:0] operation;
      logic       pin_a;
      logic       pin_b;
      logic       switch_level;
   } cmd_type;

   // Gray transition step for previous code and current code
   function automatic logic signed [1:0] gray_delta(input logic [1:0] prev_ab,
                                                    input logic [1:0] cur_ab);
      logic signed [1:0] d;
      case ({prev_ab, cur_ab})
         4'b0001: d = -2'sd1;
         4'b0010: d = 2'sd1;
         4'b0100: d = 2'sd1;
         4'b0111: d = -2'sd1;
         4'b1000: d = -2'sd1;
         4'b1011: d = 2'sd1;
         4'b1101: d = 2'sd1;
         4'b1110: d = -2'sd1;
         default: d = 2'sd0;
      endcase
      return d;
   endfunction

endpackage
`default_nettype wire

// ===== src/rebq_step_unit.sv =====
`default_nettype none
module rebq_step_unit (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire rebq_pkg::cmd_type      cmd,
   input  wire logic [6:0]             step_threshold,
   input  wire logic [3:0]             cooldown_polls,
   output rebq_pkg::key_event_type     detent_event,
   output logic signed [7:0]           raw_steps
);
   import rebq_pkg::*;

   logic [1:0]        prev_ab_ff, prev_ab_in;
   logic signed [7:0] acc_ff, acc_in;
   logic [3:0]        cooldown_ff, cooldown_in;

   logic [1:0]        cur_ab;
   logic signed [8:0] sum;
   logic signed [8:0] thr;

   // Closed contact reads low; A maps to bit 1, B to bit 0
   assign cur_ab = {~cmd.pin_a, ~cmd.pin_b};
   assign sum    = 9'(acc_ff) + 9'(gray_delta(prev_ab_ff, cur_ab));
   assign thr    = $signed({2'b00, step_threshold});

   // Decode, accumulate, check for a detent and serve raw reads
   always_comb begin
      prev_ab_in   = prev_ab_ff;
      acc_in       = acc_ff;
      cooldown_in  = cooldown_ff;
      detent_event = EVT_NONE;
      raw_steps    = 8'sd0;
      case (op_type'(cmd.operation))
         OP_ENCODER: begin
            prev_ab_in = cur_ab;
            if (sum > 9'sd127) begin
               acc_in = 8'sd127;
            end else if (sum < -9'sd127) begin
               acc_in = -8'sd127;
            end else begin
               acc_in = sum[7:0];
            end
         end
         OP_POLL: begin
            if (cooldown_ff != 4'd0) begin
               cooldown_in = cooldown_ff - 4'd1;
            end else if (9'(acc_ff) >= thr) begin
               detent_event = EVT_CW;
               acc_in       = 8'sd0;
               cooldown_in  = cooldown_polls;
            end else if (9'(acc_ff) <= -thr) begin
               detent_event = EVT_CCW;
               acc_in       = 8'sd0;
               cooldown_in  = cooldown_polls;
            end
         end
         OP_RAW: begin
            raw_steps = acc_ff;
            acc_in    = 8'sd0;
         end
         default: begin
         end
      endcase
   end

   // Commit state only when a transaction is processed
   always_ff @(posedge clock) begin
      if (reset) begin
         prev_ab_ff  <= 2'd0;
         acc_ff      <= 8'sd0;
         cooldown_ff <= 4'd0;
      end else if (cmd.fire) begin
         prev_ab_ff  <= prev_ab_in;
         acc_ff      <= acc_in;
         cooldown_ff <= cooldown_in;
      end
   end

endmodule
`default_nettype wire

// ===== src/rebq_button_unit.sv =====
`default_nettype none
module rebq_button_unit #(
   parameter int HOLD_BITS = 16
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire rebq_pkg::cmd_type      cmd,
   input  wire logic [7:0]             debounce_polls,
   input  wire logic [15:0]            long_press_polls,
   output rebq_pkg::key_event_type     button_event
);
   import rebq_pkg::*;

   localparam int CMP_BITS = (HOLD_BITS > 16) ? HOLD_BITS : 16;
   localparam logic [HOLD_BITS-1:0] HOLD_MAX = {HOLD_BITS{1'b1}};

   phase_type             phase_ff, phase_in;
   logic [HOLD_BITS-1:0]  hold_ff, hold_in;
   logic [HOLD_BITS-1:0]  hold_inc;

   assign hold_inc = (hold_ff == HOLD_MAX) ? hold_ff : hold_ff + 1'b1;

   // State register
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PHASE_RELEASED;
         hold_ff  <= '0;
      end else if (cmd.fire) begin
         phase_ff <= phase_in;
         hold_ff  <= hold_in;
      end
   end

   // Debounce, short and long press qualification on poll ticks
   always_comb begin
      phase_in     = phase_ff;
      hold_in      = hold_ff;
      button_event = EVT_NONE;
      if (op_type'(cmd.operation) == OP_POLL) begin
         if (!cmd.switch_level) begin
            hold_in = hold_inc;
            if (phase_ff == PHASE_RELEASED &&
                CMP_BITS'(hold_inc) >= CMP_BITS'(debounce_polls)) begin
               phase_in = PHASE_VALID;
            end
            if (phase_in == PHASE_VALID &&
                CMP_BITS'(hold_inc) >= CMP_BITS'(long_press_polls)) begin
               button_event = EVT_LONG;
               phase_in     = PHASE_LONG;
               hold_in      = '0;
            end
         end else begin
            case (phase_ff)
               PHASE_VALID: button_event = EVT_SHORT;
               default:     button_event = EVT_NONE;
            endcase
            hold_in  = '0;
            phase_in = PHASE_RELEASED;
         end
      end
   end

endmodule
`default_nettype wire

// ===== src/rotary_encoder_button_qualifier.sv =====
`default_nettype none
// Rotary encoder and push button qualifier. Encoder pin-change, poll-tick and
// raw-read transactions enter on the req_ channel and each yields exactly one
// rsp_ transaction carrying a key event and, for a raw read, the signed step
// count. One transaction is accepted per clock while req_stall is low; its
// result passes through the input register and then the result register,
// which a stall on rsp_ can delay. The step accumulator, cooldown counter and
// button phase all update at the edge that loads the result register.
// Registers at byte addresses 0, 4, 8, 12: step threshold, cooldown polls,
// debounce polls, long-press polls. Write them only while no transaction is
// in flight.
module rotary_encoder_button_qualifier #(
   parameter int HOLD_BITS = 16
) (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      req_valid,
   output logic                           req_stall,
   input  wire rebq_pkg::req_payload_type req_payload,
   output logic                           rsp_valid,
   input  wire logic                      rsp_stall,
   output rebq_pkg::rsp_payload_type      rsp_payload,
   input  wire logic                      csr_psel,
   input  wire logic                      csr_penable,
   input  wire logic                      csr_pwrite,
   input  wire logic [3:0]                csr_paddr,
   input  wire logic [31:0]               csr_pwdata,
   output logic [31:0]                    csr_prdata,
   output logic                           csr_pready
);
   import rebq_pkg::*;

   logic [6:0]  step_threshold_ff;
   logic [3:0]  cooldown_polls_ff;
   logic [7:0]  debounce_polls_ff;
   logic [15:0] long_press_ff;

   logic            stage_valid_ff, stage_valid_in;
   req_payload_type stage_ff;
   logic            rsp_valid_ff, rsp_valid_in;
   rsp_payload_type rsp_ff;

   logic            advance;
   logic            req_accept;
   logic            csr_write;
   cmd_type         cmd;
   key_event_type   detent_event;
   key_event_type   button_event;
   logic signed [7:0] raw_steps;

   // Configuration registers
   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         step_threshold_ff <= STEP_THRESHOLD_RST;
         cooldown_polls_ff <= COOLDOWN_POLLS_RST;
         debounce_polls_ff <= DEBOUNCE_POLLS_RST;
         long_press_ff     <= LONG_PRESS_RST;
      end else if (csr_write) begin
         case (csr_paddr[3:2])
            CSR_STEP_THRESHOLD: step_threshold_ff <= csr_pwdata[6:0];
            CSR_COOLDOWN_POLLS: cooldown_polls_ff <= csr_pwdata[3:0];
            CSR_DEBOUNCE_POLLS: debounce_polls_ff <= csr_pwdata[7:0];
            CSR_LONG_PRESS:     long_press_ff     <= csr_pwdata[15:0];
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      case (csr_paddr[3:2])
         CSR_STEP_THRESHOLD: csr_prdata = {25'd0, step_threshold_ff};
         CSR_COOLDOWN_POLLS: csr_prdata = {28'd0, cooldown_polls_ff};
         CSR_DEBOUNCE_POLLS: csr_prdata = {24'd0, debounce_polls_ff};
         CSR_LONG_PRESS:     csr_prdata = {16'd0, long_press_ff};
         default:            csr_prdata = 32'd0;
      endcase
   end

   // Handshake: advance the stage when the result register is free or drains
   assign advance    = stage_valid_ff && (!rsp_valid_ff || !rsp_stall);
   assign req_stall  = stage_valid_ff && !advance;
   assign req_accept = req_valid && !req_stall;

   always_comb begin
      stage_valid_in = stage_valid_ff;
      if (req_accept) begin
         stage_valid_in = 1'b1;
      end else if (advance) begin
         stage_valid_in = 1'b0;
      end
      rsp_valid_in = rsp_valid_ff;
      if (advance) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   // Input register
   always_ff @(posedge clock) begin
      if (reset) begin
         stage_valid_ff <= 1'b0;
      end else begin
         stage_valid_ff <= stage_valid_in;
      end
      if (req_accept) begin
         stage_ff <= req_payload;
      end
   end

   assign cmd.fire         = advance;
   assign cmd.operation    = stage_ff.operation;
   assign cmd.pin_a        = stage_ff.pin_a;
   assign cmd.pin_b        = stage_ff.pin_b;
   assign cmd.switch_level = stage_ff.switch_level;

   rebq_step_unit u_step (
      .clock          (clock),
      .reset          (reset),
      .cmd            (cmd),
      .step_threshold (step_threshold_ff),
      .cooldown_polls (cooldown_polls_ff),
      .detent_event   (detent_event),
      .raw_steps      (raw_steps)
   );

   rebq_button_unit #(
      .HOLD_BITS (HOLD_BITS)
   ) u_button (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .debounce_polls   (debounce_polls_ff),
      .long_press_polls (long_press_ff),
      .button_event     (button_event)
   );

   // Result register; a button event overrides a same-tick detent
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      if (advance) begin
         rsp_ff.key_event <= (button_event != EVT_NONE) ? button_event : detent_event;
         rsp_ff.raw_steps <= raw_steps;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

`ifndef SYNTH
   // A stalled stage keeps its transaction
   a_stage_hold: assert property (@(posedge clock) disable iff (reset)
      (stage_valid_ff && rsp_valid_ff && rsp_stall) |=> stage_valid_ff)
      else $error("input stage dropped a stalled transaction");

   // Raw count only comes with no event
   a_raw_no_event: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_payload.raw_steps != 8'sd0) |->
      (rsp_payload.key_event == EVT_NONE))
      else $error("raw step count returned with an event");

   // The accumulator saturates short of the most negative code
   a_raw_sat: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_payload.raw_steps != -8'sd128))
      else $error("step accumulator passed its saturation limit");

   // Every processed transaction reaches the result register
   a_result_loaded: assert property (@(posedge clock) disable iff (reset)
      advance |=> rsp_valid)
      else $error("processed transaction left no result");
`endif

endmodule
`default_nettype wire

// ===== test/testbench.sv =====
`default_nettype none
module testbench;
   import rebq_pkg::*;

   localparam int HOLD_BITS = 16;
   localparam logic [1:0] OP_UNUSED = 2'd3;
   localparam int ITEMS_PER_SETTING = 150;
   localparam int CYCLE_LIMIT = 1_000_000;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic            req_valid = 1'b0;
   logic            req_stall;
   req_payload_type req_payload = '0;
   logic            rsp_valid;
   logic            rsp_stall = 1'b0;
   rsp_payload_type rsp_payload;
   logic            csr_psel = 1'b0;
   logic            csr_penable = 1'b0;
   logic            csr_pwrite = 1'b0;
   logic [3:0]      csr_paddr = '0;
   logic [31:0]     csr_pwdata = '0;
   logic [31:0]     csr_prdata;
   logic            csr_pready;

   rotary_encoder_button_qualifier #(
      .HOLD_BITS(HOLD_BITS)
   ) u_dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // Register copies and qualifier state for prediction
   logic [6:0]           cfg_threshold  = STEP_THRESHOLD_RST;
   logic [3:0]           cfg_cooldown   = COOLDOWN_POLLS_RST;
   logic [7:0]           cfg_debounce   = DEBOUNCE_POLLS_RST;
   logic [15:0]          cfg_long_press = LONG_PRESS_RST;
   logic [1:0]           track_code     = '0;
   int                   track_steps    = 0;
   logic [3:0]           track_cooldown = '0;
   phase_type            track_phase    = PHASE_RELEASED;
   logic [HOLD_BITS-1:0] track_hold     = '0;

   // Step per {previous code, current code}
   int gray_step [16] = '{0, -1, 1, 0, 1, 0, 0, -1, -1, 0, 0, 1, 0, 1, -1, 0};

   // Next code for one clockwise or counterclockwise transition
   logic [1:0] cw_next  [4] = '{2'd2, 2'd0, 2'd3, 2'd1};
   logic [1:0] ccw_next [4] = '{2'd1, 2'd3, 2'd0, 2'd2};

   req_payload_type pending_q [$];
   rsp_payload_type key_results_q [$];

   logic [1:0] enc_code = '0;
   logic       calm = 1'b0;
   int         idle_left = 0;
   int         stall_left = 0;
   int         cycle_count = 0;
   int         fault_count = 0;
   int         results_checked = 0;
   int         settings_count = 0;
   int         cw_seen = 0;
   int         ccw_seen = 0;
   int         short_seen = 0;
   int         long_seen = 0;
   int         raw_seen = 0;

   // Advance the qualifier state by one transaction and return its result
   function automatic rsp_payload_type predict_key(req_payload_type item);
      rsp_payload_type res;
      logic [1:0]      code;
      int              sum;
      int              thr;
      res  = '0;
      code = {~item.pin_a, ~item.pin_b};
      thr  = int'(cfg_threshold);
      if (item.operation == OP_ENCODER) begin
         sum = track_steps + gray_step[{track_code, code}];
         if (sum > 127) sum = 127;
         if (sum < -127) sum = -127;
         track_steps = sum;
         track_code  = code;
      end else if (item.operation == OP_POLL) begin
         if (track_cooldown != 0) begin
            track_cooldown = track_cooldown - 4'd1;
         end else if (track_steps >= thr) begin
            res.key_event  = EVT_CW;
            track_steps    = 0;
            track_cooldown = cfg_cooldown;
         end else if (track_steps <= -thr) begin
            res.key_event  = EVT_CCW;
            track_steps    = 0;
            track_cooldown = cfg_cooldown;
         end
         // Button events take priority over a detent on the same poll
         if (!item.switch_level) begin
            if (track_hold != '1) track_hold = track_hold + 1'b1;
            if (track_phase == PHASE_RELEASED && track_hold >= cfg_debounce)
               track_phase = PHASE_VALID;
            if (track_hold >= cfg_long_press && track_phase == PHASE_VALID) begin
               res.key_event = EVT_LONG;
               track_phase   = PHASE_LONG;
               track_hold    = '0;
            end
         end else begin
            if (track_phase == PHASE_VALID) res.key_event = EVT_SHORT;
            track_hold  = '0;
            track_phase = PHASE_RELEASED;
         end
      end else if (item.operation == OP_RAW) begin
         res.raw_steps = track_steps[7:0];
         track_steps   = 0;
      end
      return res;
   endfunction

   // Mostly short gaps, a few long ones, none while calm
   function automatic int idle_length();
      int pick;
      pick = $urandom_range(0, 99);
      if (calm) return 0;
      if (pick < 60) return 0;
      if (pick < 90) return $urandom_range(1, 3);
      return $urandom_range(4, 30);
   endfunction

   // Request driver: predict on acceptance, then present the next transaction
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         idle_left <= 0;
      end else if (!req_valid || !req_stall) begin
         if (req_valid) key_results_q.push_back(predict_key(req_payload));
         if (idle_left > 0) begin
            req_valid <= 1'b0;
            idle_left <= idle_left - 1;
         end else if (pending_q.size() > 0) begin
            req_payload <= pending_q.pop_front();
            req_valid   <= 1'b1;
            idle_left   <= idle_length();
            if ($urandom_range(0, 149) == 0) calm <= !calm;
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // Result monitor: compare each transaction with the oldest prediction
   always @(posedge clock) begin : result_monitor
      rsp_payload_type want;
      if (reset) begin
         rsp_stall  <= 1'b0;
         stall_left <= 0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (key_results_q.size() == 0) begin
               $display("%0t: unexpected result key_event %0d raw_steps %0d", $realtime,
                        rsp_payload.key_event, rsp_payload.raw_steps);
               fault_count++;
            end else begin
               want = key_results_q.pop_front();
               results_checked++;
               if (rsp_payload.key_event !== want.key_event) begin
                  $display("%0t: key_event expected %0d, actual %0d", $realtime,
                           want.key_event, rsp_payload.key_event);
                  fault_count++;
               end
               if (rsp_payload.raw_steps !== want.raw_steps) begin
                  $display("%0t: raw_steps expected %0d, actual %0d", $realtime,
                           want.raw_steps, rsp_payload.raw_steps);
                  fault_count++;
               end
               case (want.key_event)
                  EVT_CW:    cw_seen++;
                  EVT_CCW:   ccw_seen++;
                  EVT_SHORT: short_seen++;
                  EVT_LONG:  long_seen++;
                  default:   if (want.raw_steps != 0) raw_seen++;
               endcase
            end
         end
         // Stall in runs of random length
         if (stall_left > 0) begin
            stall_left <= stall_left - 1;
         end else if (rsp_stall) begin
            rsp_stall  <= 1'b0;
            stall_left <= $urandom_range(0, 6);
         end else if (!calm && $urandom_range(0, 99) < 35) begin
            rsp_stall  <= 1'b1;
            stall_left <= idle_length();
         end
      end
   end

   // Bound the run
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("status: fail");
         $finish;
      end
   end

   task automatic push_item(logic [1:0] op, logic a, logic b, logic sw);
      req_payload_type item;
      item.operation    = op;
      item.pin_a        = a;
      item.pin_b        = b;
      item.switch_level = sw;
      if (op == OP_ENCODER) enc_code = {~a, ~b};
      pending_q.push_back(item);
   endtask

   task automatic send_code(logic [1:0] code);
      push_item(OP_ENCODER, ~code[1], ~code[0], 1'($urandom_range(0, 1)));
   endtask

   task automatic step(logic clockwise);
      send_code(clockwise ? cw_next[enc_code] : ccw_next[enc_code]);
   endtask

   task automatic turn(logic clockwise, int count);
      repeat (count) step(clockwise);
   endtask

   task automatic poll(logic sw);
      push_item(OP_POLL, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)), sw);
   endtask

   task automatic raw_read();
      push_item(OP_RAW, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                1'($urandom_range(0, 1)));
   endtask

   // Hold until every transaction has been accepted and answered
   task automatic drain();
      while (pending_q.size() != 0 || req_valid || key_results_q.size() != 0)
         @(negedge clock);
   endtask

   // Write one register, then read it back
   task automatic write_register(logic [1:0] index, logic [31:0] field);
      logic [31:0] mask;
      logic [31:0] value;
      logic [31:0] readback;
      case (index)
         CSR_STEP_THRESHOLD: mask = 32'h7f;
         CSR_COOLDOWN_POLLS: mask = 32'hf;
         CSR_DEBOUNCE_POLLS: mask = 32'hff;
         default:            mask = 32'hffff;
      endcase
      case (index)
         CSR_STEP_THRESHOLD: cfg_threshold  = field[6:0];
         CSR_COOLDOWN_POLLS: cfg_cooldown   = field[3:0];
         CSR_DEBOUNCE_POLLS: cfg_debounce   = field[7:0];
         default:            cfg_long_press = field[15:0];
      endcase
      value = field & mask;
      if ($urandom_range(0, 1)) value = value | ($urandom() & ~mask);
      @(posedge clock);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= {index, 2'b00};
      csr_pwdata  <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      readback = csr_prdata;
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      if (readback !== (field & mask)) begin
         $display("%0t: register %0d read expected %0h, actual %0h", $realtime, index,
                  field & mask, readback);
         fault_count++;
      end
   endtask

   task automatic apply_settings(int thr, int cool, int deb, int hold_polls);
      write_register(CSR_STEP_THRESHOLD, thr);
      write_register(CSR_COOLDOWN_POLLS, cool);
      write_register(CSR_DEBOUNCE_POLLS, deb);
      write_register(CSR_LONG_PRESS, hold_polls);
      settings_count++;
   endtask

   // Queue random traffic: mostly rotations and presses, some reads and noise
   task automatic run_random(int count);
      int   pick;
      int   len;
      logic dir;
      while (pending_q.size() < count) begin
         pick = $urandom_range(0, 99);
         dir  = 1'($urandom_range(0, 1));
         if (pick < 45) begin
            turn(dir, $urandom_range(1, int'(cfg_threshold) + 2));
            if ($urandom_range(0, 6) == 0) begin
               step(!dir);
               step(dir);
            end
            repeat ($urandom_range(1, 3)) poll($urandom_range(0, 9) != 0);
         end else if (pick < 72) begin
            case ($urandom_range(0, 5))
               0, 1:    len = int'(cfg_debounce) + int'($urandom_range(0, 2)) - 1;
               2, 3:    len = int'(cfg_long_press) + int'($urandom_range(0, 2)) - 1;
               default: len = $urandom_range(1, 8);
            endcase
            if (len < 1) len = 1;
            if (len > 400) len = 400;
            repeat (len) begin
               if ($urandom_range(0, 4) == 0) step(1'($urandom_range(0, 1)));
               poll(1'b0);
            end
            if ($urandom_range(0, 5) != 0) poll(1'b1);
         end else if (pick < 84) begin
            turn(dir, $urandom_range(0, 5));
            raw_read();
         end else begin
            push_item(2'($urandom_range(0, 3)), 1'($urandom_range(0, 1)),
                      1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
         end
      end
      drain();
   endtask

   initial begin
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // Reset settings: each operation, detents both ways, presses, raw reads
      raw_read();
      push_item(OP_UNUSED, 1'b1, 1'b1, 1'b1);
      push_item(OP_UNUSED, 1'b0, 1'b0, 1'b0);
      turn(1'b1, 4);
      poll(1'b1);
      poll(1'b1);
      poll(1'b1);
      turn(1'b0, 4);
      poll(1'b1);
      send_code(enc_code ^ 2'b11);
      poll(1'b0);
      poll(1'b0);
      poll(1'b1);
      turn(1'b1, 3);
      raw_read();
      turn(1'b0, 2);
      raw_read();
      // A release on the same poll as a detent reports the press
      turn(1'b1, 4);
      poll(1'b0);
      poll(1'b0);
      poll(1'b0);
      turn(1'b1, 4);
      poll(1'b1);
      drain();

      apply_settings(1, 0, 1, 1);
      run_random(ITEMS_PER_SETTING);

      // Largest settings: drive the accumulator into both limits
      apply_settings(127, 15, 255, 65535);
      turn(1'b1, 130);
      raw_read();
      turn(1'b0, 130);
      raw_read();
      turn(1'b1, 130);
      poll(1'b1);
      drain();
      run_random(ITEMS_PER_SETTING);

      // Zero threshold, debounce and long press counts
      apply_settings(0, 0, 0, 0);
      poll(1'b0);
      poll(1'b0);
      poll(1'b1);
      turn(1'b0, 2);
      poll(1'b1);
      drain();
      run_random(ITEMS_PER_SETTING);

      repeat (5) begin
         apply_settings($urandom_range(0, 4) == 0 ? $urandom_range(1, 127)
                                                 : $urandom_range(1, 8),
                        $urandom_range(0, 15),
                        $urandom_range(1, 12),
                        $urandom_range(1, 60));
         run_random(ITEMS_PER_SETTING);
      end

      repeat (4) @(posedge clock);
      $display("checked %0d results across %0d register settings", results_checked,
               settings_count);
      $display("events: %0d cw, %0d ccw, %0d short, %0d long, %0d nonzero raw reads",
               cw_seen, ccw_seen, short_seen, long_seen, raw_seen);
      if (fault_count == 0) $display("status: pass");
      else $display("status: fail");
      $finish;
   end

endmodule
`default_nettype wire

// ===== files.f =====
src/rebq_pkg.sv
src/rebq_step_unit.sv
src/rebq_button_unit.sv
src/rotary_encoder_button_qualifier.sv
test/testbench.sv
